[src/ridbfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ridbfp_pkg
// Types, codes, field tables and decode helpers for the remote id bitmap
// frame parser.
// ----------------------------------------------------------------------------
package ridbfp_pkg;

    localparam int MAX_BITMAP_BYTES = 8;
    localparam int FIELD_COUNT      = 21;
    localparam int FIFO_DEPTH       = 4;

    localparam logic [7:0] MAGIC_BYTE = 8'hFF;
    localparam logic [8:0] HDR_LEN    = 9'd3;

    // event codes
    localparam logic [2:0] EV_VALUE    = 3'd0;
    localparam logic [2:0] EV_BITMAP   = 3'd1;
    localparam logic [2:0] EV_COMPLETE = 3'd2;
    localparam logic [2:0] EV_BADHDR   = 3'd3;
    localparam logic [2:0] EV_TRUNC    = 3'd4;

    // fields with their own layout or unit
    localparam logic [4:0] FLD_ID_MAIN   = 5'd1;
    localparam logic [4:0] FLD_ID_AUX    = 5'd2;
    localparam logic [4:0] FLD_POS_OP    = 5'd6;
    localparam logic [4:0] FLD_ALT_OP    = 5'd7;
    localparam logic [4:0] FLD_POS_UA    = 5'd8;
    localparam logic [4:0] FLD_TENTHS_A  = 5'd9;
    localparam logic [4:0] FLD_TENTHS_B  = 5'd10;
    localparam logic [4:0] FLD_HEIGHT    = 5'd11;
    localparam logic [4:0] FLD_VSPEED    = 5'd12;
    localparam logic [4:0] FLD_ALT_A     = 5'd13;
    localparam logic [4:0] FLD_ALT_B     = 5'd14;
    localparam logic [4:0] FLD_TIMESTAMP = 5'd20;

    // floor(t / 1000) = (t * DIV_MAGIC) >> DIV_SHIFT for t < 2^20
    localparam logic [20:0] DIV_MAGIC = 21'd1073742;
    localparam int          DIV_SHIFT = 30;

    localparam int QUO_W = 39;
    localparam int REM_W = 20;

    typedef struct packed {
        logic [2:0]  ev;
        logic [4:0]  fn;
        logic [1:0]  part;
        logic [63:0] raw;
        logic [32:0] scaled;
        logic        unk;
        logic        last;
    } t_result;

    typedef struct packed {
        logic             vld;
        logic             div;
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] rem;
        t_result          res;
    } t_slot;

    typedef struct packed {
        logic        unk;
        logic [32:0] scaled;
    } t_decoded;

    function automatic logic [4:0] f_field_len(input logic [4:0] fn);
        logic [4:0] len;
        case (fn)
            5'd1:    len = 5'd20;
            5'd2:    len = 5'd8;
            5'd6:    len = 5'd8;
            5'd7:    len = 5'd2;
            5'd8:    len = 5'd8;
            5'd9:    len = 5'd2;
            5'd10:   len = 5'd2;
            5'd11:   len = 5'd2;
            5'd13:   len = 5'd2;
            5'd14:   len = 5'd2;
            5'd20:   len = 5'd6;
            5'd0:    len = 5'd0;
            default: len = (fn > 5'd21) ? 5'd0 : 5'd1;
        endcase
        return len;
    endfunction

    function automatic logic [4:0] f_chunk_len(input logic [4:0] fn);
        logic [4:0] len;
        case (fn)
            FLD_ID_MAIN, FLD_ID_AUX: len = 5'd8;
            FLD_POS_OP, FLD_POS_UA:  len = 5'd4;
            default:                 len = f_field_len(fn);
        endcase
        return len;
    endfunction

    // 256^k / 1000 split into quotient and remainder
    function automatic logic [30:0] f_ms_quo(input logic [2:0] k);
        logic [30:0] q;
        case (k)
            3'd2:    q = 31'd65;
            3'd3:    q = 31'd16777;
            3'd4:    q = 31'd4294967;
            3'd5:    q = 31'd1099511627;
            default: q = 31'd0;
        endcase
        return q;
    endfunction

    function automatic logic [9:0] f_ms_rem(input logic [2:0] k);
        logic [9:0] r;
        case (k)
            3'd0:    r = 10'd1;
            3'd1:    r = 10'd256;
            3'd2:    r = 10'd536;
            3'd3:    r = 10'd216;
            3'd4:    r = 10'd296;
            3'd5:    r = 10'd776;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    function automatic t_decoded f_decode(input logic [4:0] fn, input logic [63:0] raw);
        t_decoded          d;
        logic signed [32:0] v16;
        v16      = {{17{raw[15]}}, raw[15:0]};
        d.unk    = 1'b0;
        d.scaled = {25'd0, raw[7:0]};
        case (fn)
            FLD_ID_MAIN, FLD_ID_AUX, FLD_TIMESTAMP: begin
                d.scaled = '0;
            end
            FLD_POS_OP, FLD_POS_UA: begin
                d.scaled = {raw[31], raw[31:0]};
            end
            FLD_ALT_OP, FLD_ALT_A, FLD_ALT_B: begin
                d.scaled = v16 - 33'sd2000;
            end
            FLD_HEIGHT: begin
                d.scaled = v16 - 33'sd18000;
            end
            FLD_TENTHS_A, FLD_TENTHS_B: begin
                if (raw[15:0] == 16'hFFFF) begin
                    d.unk    = 1'b1;
                    d.scaled = -33'sd10;
                end else begin
                    d.scaled = {17'd0, raw[15:0]};
                end
            end
            FLD_VSPEED: begin
                if (raw[7:0] == 8'hFF) begin
                    d.unk    = 1'b1;
                    d.scaled = -33'sd2;
                end else if (raw[7]) begin
                    d.scaled = 33'd0 - {26'd0, raw[6:0]};
                end else begin
                    d.scaled = {26'd0, raw[6:0]};
                end
            end
            default: begin
                d.scaled = {25'd0, raw[7:0]};
            end
        endcase
        return d;
    endfunction

    function automatic t_result f_end_result(input logic [2:0] ev, input logic [8:0] pos);
        t_result r;
        r        = '0;
        r.ev     = ev;
        r.raw    = {55'd0, pos};
        r.last   = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

[src/remote_id_bitmap_frame_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// remote_id_bitmap_frame_parser
// Parses a remote id bitmap frame byte by byte into field, bitmap and end items.
// ----------------------------------------------------------------------------
// One frame byte is taken per clock while tready is high. Each byte gives up
// to two result items, which pass through a parse register, then a
// four-entry output queue, with the one multiplier (timestamp ms to seconds)
// between them. Input tready is high while the queue has room for
// two more items beyond those in flight, so bytes flow at one per cycle as long
// as the sink takes one item per cycle; a byte giving two items makes the sink
// take an extra item.
// ----------------------------------------------------------------------------
module remote_id_bitmap_frame_parser
    import ridbfp_pkg::*;
#(
    parameter int MAX_BM_BYTES = MAX_BITMAP_BYTES
)
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [7:0]    i_s_axis_tdata,   // data_byte
    input  wire logic [0:0]    i_s_axis_tuser,   // frame_start
    input  wire logic          i_s_axis_tlast,   // frame_end
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [103:0]       o_m_axis_tdata,   // field_number, part, raw_value, scaled_value
    output logic [3:0]         o_m_axis_tuser,   // event_res, unknown
    output logic               o_m_axis_tlast    // last_of_run
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_VERSION = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_BITMAP  = 3'd3;
    localparam logic [2:0] PH_FIELD   = 3'd4;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W = CNT_W + 1;

    logic [2:0]       r_phase, n_phase;
    logic [8:0]       r_byte_pos, n_byte_pos;
    logic [8:0]       r_limit, n_limit;
    logic [7:0]       r_bitmap [0:2];
    logic [7:0]       n_bitmap [0:2];
    logic [3:0]       r_bm_count, n_bm_count;
    logic [4:0]       r_field, n_field;
    logic [4:0]       r_bif, n_bif;
    logic [63:0]      r_asm, n_asm;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [REM_W-1:0] r_rem, n_rem;
    t_slot            r_s0, n_s0, r_s1, n_s1;

    t_result          r_fifo [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic             s_acc;
    logic [7:0]       in_byte;
    logic             in_start;
    logic             in_end;

    logic             bm_wr;
    logic [7:0]       bm_next [0:2];
    logic [20:0]      sel_vec;
    logic             nxt_found;
    logic [4:0]       nxt_fn;
    logic [8:0]       pos_inc;
    logic [3:0]       bm_count_inc;
    logic             adv_over;

    logic             fld_ok;
    logic [4:0]       fld_size;
    logic [4:0]       fld_chunk;
    logic [4:0]       fld_pos;
    logic [1:0]       fld_part;
    logic             fld_emit;
    logic [63:0]      asm_new;
    logic [4:0]       bif_inc;
    logic [QUO_W-1:0] quo_new;
    logic [REM_W-1:0] rem_new;
    t_decoded         fld_dec;

    logic             do_adv;
    logic             adv_hi;
    t_slot            adv_slot;

    logic [40:0]      div_prod;
    logic [QUO_W-1:0] div_sum;
    t_result          res0;
    logic [OCC_W-1:0] occ;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_hi;

    assign in_byte  = i_s_axis_tdata;
    assign in_start = i_s_axis_tuser[0];
    assign in_end   = i_s_axis_tlast;
    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;

    // bitmap bytes as they stand after this byte
    assign bm_wr = (r_phase == PH_BITMAP) && (r_bm_count < 4'd3) && !in_start;

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            bm_next[b] = r_bitmap[b];
            if (bm_wr && (r_bm_count[1:0] == 2'(b))) begin
                bm_next[b] = in_byte;
            end
        end
        for (int b = 0; b < 3; b++) begin
            for (int j = 0; j < 7; j++) begin
                sel_vec[b * 7 + j] = bm_next[b][7 - j];
            end
        end
    end

    // next selected field after the current one
    always_comb begin
        nxt_found = 1'b0;
        nxt_fn    = '0;
        for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
            if (sel_vec[i] && (5'(i + 1) > r_field)) begin
                nxt_found = 1'b1;
                nxt_fn    = 5'(i + 1);
            end
        end
    end

    assign pos_inc      = r_byte_pos + 9'd1;
    assign bm_count_inc = r_bm_count + 4'd1;
    assign adv_over     = ({1'b0, pos_inc} + {5'd0, f_field_len(nxt_fn)}) > {1'b0, r_limit};

    // field byte handling
    always_comb begin
        fld_ok    = (r_field != 5'd0) && (r_field <= 5'(FIELD_COUNT));
        fld_size  = f_field_len(r_field);
        fld_chunk = f_chunk_len(r_field);
        case (fld_chunk)
            5'd8: begin
                fld_pos  = {2'd0, r_bif[2:0]};
                fld_part = r_bif[4:3];
            end
            5'd4: begin
                fld_pos  = {3'd0, r_bif[1:0]};
                fld_part = r_bif[3:2];
            end
            default: begin
                fld_pos  = r_bif;
                fld_part = 2'd0;
            end
        endcase
        fld_emit = (fld_pos == fld_chunk - 5'd1) || (r_bif == fld_size - 5'd1);
        asm_new  = r_asm | ({56'd0, in_byte} << {fld_pos[2:0], 3'b000});
        bif_inc  = r_bif + 5'd1;
        quo_new  = r_quo + QUO_W'(in_byte * f_ms_quo(r_bif[2:0]));
        rem_new  = r_rem + REM_W'(in_byte * f_ms_rem(r_bif[2:0]));
        fld_dec  = f_decode(r_field, asm_new);
    end

    always_comb begin
        n_phase    = r_phase;
        n_byte_pos = r_byte_pos;
        n_limit    = r_limit;
        n_bm_count = r_bm_count;
        n_field    = r_field;
        n_bif      = r_bif;
        n_asm      = r_asm;
        n_quo      = r_quo;
        n_rem      = r_rem;
        for (int b = 0; b < 3; b++) begin
            n_bitmap[b] = r_bitmap[b];
        end
        n_s0     = '0;
        n_s1     = '0;
        do_adv   = 1'b0;
        adv_hi   = 1'b0;
        adv_slot = '0;

        if (s_acc) begin
            if (in_start) begin
                n_phase    = PH_IDLE;
                n_byte_pos = '0;
                n_limit    = '0;
                n_bm_count = '0;
                n_field    = '0;
                n_bif      = '0;
                n_asm      = '0;
                n_quo      = '0;
                n_rem      = '0;
                for (int b = 0; b < 3; b++) begin
                    n_bitmap[b] = '0;
                end
                if ((in_byte != MAGIC_BYTE) || in_end) begin
                    n_s0.vld = 1'b1;
                    n_s0.res = f_end_result(EV_BADHDR, 9'd0);
                end else begin
                    n_byte_pos = 9'd1;
                    n_phase    = PH_VERSION;
                end
            end else begin
                case (r_phase)
                    PH_VERSION: begin
                        n_byte_pos = 9'd2;
                        if (in_end) begin
                            n_s0.vld = 1'b1;
                            n_s0.res = f_end_result(EV_BADHDR, 9'd0);
                            n_phase  = PH_IDLE;
                        end else begin
                            n_phase = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        n_byte_pos = HDR_LEN;
                        if (in_end) begin
                            n_limit  = HDR_LEN;
                            n_s0.vld = 1'b1;
                            n_s0.res = f_end_result(EV_COMPLETE, HDR_LEN);
                            n_phase  = PH_IDLE;
                        end else begin
                            n_limit = HDR_LEN + {1'b0, in_byte};
                            n_phase = PH_BITMAP;
                        end
                    end
                    PH_BITMAP: begin
                        for (int b = 0; b < 3; b++) begin
                            n_bitmap[b] = bm_next[b];
                        end
                        if (bm_wr) begin
                            n_s0.vld        = 1'b1;
                            n_s0.res.ev     = EV_BITMAP;
                            n_s0.res.fn     = {3'd0, r_bm_count[1:0]};
                            n_s0.res.raw    = {56'd0, in_byte};
                            n_s0.res.scaled = {25'd0, in_byte};
                        end
                        n_bm_count = bm_count_inc;
                        n_byte_pos = pos_inc;
                        if (!in_byte[0] || (bm_count_inc >= 4'(MAX_BM_BYTES)) || in_end) begin
                            do_adv = 1'b1;
                            adv_hi = bm_wr;
                        end
                    end
                    PH_FIELD: begin
                        if (!fld_ok) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_asm = fld_emit ? 64'd0 : asm_new;
                            if (r_field == FLD_TIMESTAMP) begin
                                n_quo = quo_new;
                                n_rem = rem_new;
                            end
                            if (fld_emit) begin
                                n_s0.vld        = 1'b1;
                                n_s0.div        = (r_field == FLD_TIMESTAMP);
                                n_s0.quo        = quo_new;
                                n_s0.rem        = rem_new;
                                n_s0.res.ev     = EV_VALUE;
                                n_s0.res.fn     = r_field;
                                n_s0.res.part   = fld_part;
                                n_s0.res.raw    = asm_new;
                                n_s0.res.scaled = fld_dec.scaled;
                                n_s0.res.unk    = fld_dec.unk;
                            end
                            n_bif      = bif_inc;
                            n_byte_pos = pos_inc;
                            if (bif_inc >= fld_size) begin
                                do_adv = 1'b1;
                                adv_hi = fld_emit;
                            end else if (in_end) begin
                                adv_slot.vld = 1'b1;
                                adv_slot.res = f_end_result(EV_TRUNC,
                                                            pos_inc - {4'd0, bif_inc});
                                n_phase      = PH_IDLE;
                                if (fld_emit) begin
                                    n_s1 = adv_slot;
                                end else begin
                                    n_s0 = adv_slot;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                if (do_adv) begin
                    adv_slot.vld = 1'b1;
                    if (!nxt_found) begin
                        adv_slot.res = f_end_result(EV_COMPLETE, pos_inc);
                        n_phase      = PH_IDLE;
                    end else if (in_end || adv_over) begin
                        adv_slot.res = f_end_result(EV_TRUNC, pos_inc);
                        n_phase      = PH_IDLE;
                    end else begin
                        adv_slot.vld = 1'b0;
                        n_field      = nxt_fn;
                        n_bif        = '0;
                        n_asm        = '0;
                        n_quo        = '0;
                        n_rem        = '0;
                        n_phase      = PH_FIELD;
                    end
                    if (adv_slot.vld) begin
                        if (adv_hi) begin
                            n_s1 = adv_slot;
                        end else begin
                            n_s0 = adv_slot;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_byte_pos <= '0;
            r_limit    <= '0;
            r_bm_count <= '0;
            r_field    <= '0;
            r_bif      <= '0;
            r_asm      <= '0;
            r_quo      <= '0;
            r_rem      <= '0;
            for (int b = 0; b < 3; b++) begin
                r_bitmap[b] <= '0;
            end
            r_s0       <= '0;
            r_s1       <= '0;
        end else begin
            r_phase    <= n_phase;
            r_byte_pos <= n_byte_pos;
            r_limit    <= n_limit;
            r_bm_count <= n_bm_count;
            r_field    <= n_field;
            r_bif      <= n_bif;
            r_asm      <= n_asm;
            r_quo      <= n_quo;
            r_rem      <= n_rem;
            for (int b = 0; b < 3; b++) begin
                r_bitmap[b] <= n_bitmap[b];
            end
            r_s0       <= n_s0;
            r_s1       <= n_s1;
        end
    end

    // ms to seconds: remainder part through the reciprocal
    always_comb begin
        div_prod = {21'd0, r_s0.rem} * {20'd0, DIV_MAGIC};
        div_sum  = r_s0.quo + QUO_W'(div_prod[40:DIV_SHIFT]);
        res0     = r_s0.res;
        if (r_s0.div) begin
            res0.scaled = {1'b0, div_sum[31:0]};
        end
    end

    // output queue
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign wr_ptr_hi       = r_wr_ptr + PTR_W'(1);
    assign occ             = OCC_W'(r_count) + OCC_W'(r_s0.vld) + OCC_W'(r_s1.vld);
    assign o_s_axis_tready = (occ <= OCC_W'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (r_s0.vld) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (r_s1.vld) begin
            r_fifo[wr_ptr_hi] <= r_s1.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(r_s0.vld) + PTR_W'(r_s1.vld);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(r_s0.vld) + CNT_W'(r_s1.vld) - CNT_W'(pop);
        end
    end

    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {r_fifo[r_rd_ptr].scaled, r_fifo[r_rd_ptr].raw,
                              r_fifo[r_rd_ptr].part, r_fifo[r_rd_ptr].fn};
    assign o_m_axis_tuser  = {r_fifo[r_rd_ptr].unk, r_fifo[r_rd_ptr].ev};
    assign o_m_axis_tlast  = r_fifo[r_rd_ptr].last;

endmodule
`default_nettype wire

[verif/frame_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches both stream channels of the remote id bitmap frame parser. Every
// accepted frame byte goes through a parse model of its own that queues the
// items the byte should produce. Every accepted output item is compared
// field by field with the oldest queued one. The mismatch count and the
// number of items still owed are handed back to the testbench top.
// ----------------------------------------------------------------------------
module frame_result_checker
    import ridbfp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [7:0]   i_in_byte,
    input  logic         i_in_start,
    input  logic         i_in_end,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [103:0] i_out_data,   // field_number, part, raw_value, scaled_value
    input  logic [3:0]   i_out_user,   // event_res, unknown
    input  logic         i_out_last,   // last_of_run
    output int           o_mismatches,
    output int           o_pending
);

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_VERSION,
        PARSE_LENGTH,
        PARSE_BITMAP,
        PARSE_FIELD
    } t_parse_phase;

    t_parse_phase parse_phase;
    logic [8:0]   byte_pos;
    logic [8:0]   frame_limit;
    logic [7:0]   bitmap_seen [3];
    logic [3:0]   bitmap_count;
    logic [4:0]   field_idx;
    logic [4:0]   field_byte;
    logic [63:0]  field_acc;
    t_result      expected_items [$];
    int           fail_count = 0;

    function automatic int field_bytes(input logic [4:0] n);
        case (n)
            FLD_ID_MAIN:                                  return 20;
            FLD_ID_AUX, FLD_POS_OP, FLD_POS_UA:           return 8;
            FLD_ALT_OP, FLD_TENTHS_A, FLD_TENTHS_B,
            FLD_HEIGHT, FLD_ALT_A, FLD_ALT_B:             return 2;
            FLD_TIMESTAMP:                                return 6;
            default: return (n >= 1 && n <= FIELD_COUNT) ? 1 : 0;
        endcase
    endfunction

    function automatic int chunk_bytes(input logic [4:0] n);
        case (n)
            FLD_ID_MAIN, FLD_ID_AUX: return 8;
            FLD_POS_OP, FLD_POS_UA:  return 4;
            default:                 return field_bytes(n);
        endcase
    endfunction

    // {unknown, scaled}
    function automatic logic [33:0] scale_field(input logic [4:0] n, input logic [63:0] raw);
        logic signed [32:0] half;
        logic [63:0]        secs;
        half = {{17{raw[15]}}, raw[15:0]};
        secs = raw / 64'd1000;
        case (n)
            FLD_ID_MAIN, FLD_ID_AUX: return {1'b0, 33'd0};
            FLD_POS_OP, FLD_POS_UA:  return {1'b0, raw[31], raw[31:0]};
            FLD_ALT_OP, FLD_ALT_A, FLD_ALT_B: return {1'b0, half - 33'sd2000};
            FLD_HEIGHT:              return {1'b0, half - 33'sd18000};
            FLD_TENTHS_A, FLD_TENTHS_B: begin
                if (raw == 64'hFFFF) return {1'b1, -33'sd10};
                return {1'b0, raw[32:0]};
            end
            FLD_VSPEED: begin
                if (raw == 64'hFF) return {1'b1, -33'sd2};
                if (raw[7]) return {1'b0, 33'd0 - {26'd0, raw[6:0]}};
                return {1'b0, 26'd0, raw[6:0]};
            end
            FLD_TIMESTAMP:           return {1'b0, 1'b0, secs[31:0]};
            default:                 return {1'b0, raw[32:0]};
        endcase
    endfunction

    function automatic bit is_selected(input int n);
        return bitmap_seen[(n - 1) / 7][7 - (n - 1) % 7];
    endfunction

    task automatic queue_item(input logic [2:0] ev, input logic [4:0] fn, input logic [1:0] part,
                              input logic [63:0] raw, input logic [33:0] unk_sc,
                              input logic last);
        t_result r;
        r.ev     = ev;
        r.fn     = fn;
        r.part   = part;
        r.raw    = raw;
        r.scaled = unk_sc[32:0];
        r.unk    = unk_sc[33];
        r.last   = last;
        expected_items.push_back(r);
    endtask

    task automatic queue_end(input logic [2:0] ev, input logic [8:0] pos);
        queue_item(ev, 5'd0, 2'd0, {55'd0, pos}, 34'd0, 1'b1);
        parse_phase = PARSE_IDLE;
    endtask

    task automatic clear_state();
        parse_phase    = PARSE_IDLE;
        byte_pos       = '0;
        frame_limit    = '0;
        bitmap_seen[0] = '0;
        bitmap_seen[1] = '0;
        bitmap_seen[2] = '0;
        bitmap_count   = '0;
        field_idx      = '0;
        field_byte     = '0;
        field_acc      = '0;
    endtask

    // pick the next selected field or close the frame
    task automatic next_field(input bit ended);
        int n;
        n = int'(field_idx) + 1;
        while (n <= FIELD_COUNT && !is_selected(n)) n++;
        if (n > FIELD_COUNT) begin
            queue_end(EV_COMPLETE, byte_pos);
        end else if (ended || int'(byte_pos) + field_bytes(5'(n)) > int'(frame_limit)) begin
            queue_end(EV_TRUNC, byte_pos);
        end else begin
            field_idx   = 5'(n);
            field_byte  = '0;
            field_acc   = '0;
            parse_phase = PARSE_FIELD;
        end
    endtask

    task automatic predict_byte(input logic [7:0] d, input logic start, input logic fin);
        int size;
        int chunk;
        int slot;
        if (start) begin
            clear_state();
            if (d != MAGIC_BYTE || fin) begin
                queue_end(EV_BADHDR, 9'd0);
            end else begin
                byte_pos    = 9'd1;
                parse_phase = PARSE_VERSION;
            end
            return;
        end
        case (parse_phase)
            PARSE_VERSION: begin
                byte_pos = 9'd2;
                if (fin) queue_end(EV_BADHDR, 9'd0);
                else parse_phase = PARSE_LENGTH;
            end
            PARSE_LENGTH: begin
                byte_pos    = HDR_LEN;
                frame_limit = HDR_LEN + {1'b0, d};
                if (fin) begin
                    frame_limit = HDR_LEN;
                    next_field(1'b1);
                end else begin
                    parse_phase = PARSE_BITMAP;
                end
            end
            PARSE_BITMAP: begin
                if (bitmap_count < 4'd3) begin
                    bitmap_seen[bitmap_count] = d;
                    queue_item(EV_BITMAP, {1'b0, bitmap_count}, 2'd0, {56'd0, d},
                               {1'b0, 25'd0, d}, 1'b0);
                end
                bitmap_count = bitmap_count + 4'd1;
                byte_pos     = byte_pos + 9'd1;
                if (!d[0] || bitmap_count >= MAX_BITMAP_BYTES || fin) next_field(fin);
            end
            PARSE_FIELD: begin
                size  = field_bytes(field_idx);
                chunk = chunk_bytes(field_idx);
                slot  = int'(field_byte) % chunk;
                field_acc = field_acc | ({56'd0, d} << (8 * slot));
                if (slot == chunk - 1 || int'(field_byte) == size - 1) begin
                    queue_item(EV_VALUE, field_idx, 2'(int'(field_byte) / chunk), field_acc,
                               scale_field(field_idx, field_acc), 1'b0);
                    field_acc = '0;
                end
                field_byte = field_byte + 5'd1;
                byte_pos   = byte_pos + 9'd1;
                if (int'(field_byte) >= size) next_field(fin);
                else if (fin) queue_end(EV_TRUNC, byte_pos - {4'd0, field_byte});
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_item();
        t_result want;
        if (expected_items.size() == 0) begin
            $error("unexpected item: event %0d field %0d raw %0h",
                   i_out_user[2:0], i_out_data[4:0], i_out_data[70:7]);
            fail_count++;
        end else begin
            want = expected_items.pop_front();
            compare_field("event_res", 64'(want.ev), 64'(i_out_user[2:0]));
            compare_field("field_number", 64'(want.fn), 64'(i_out_data[4:0]));
            compare_field("part", 64'(want.part), 64'(i_out_data[6:5]));
            compare_field("raw_value", want.raw, i_out_data[70:7]);
            compare_field("scaled_value", 64'(want.scaled), 64'(i_out_data[103:71]));
            compare_field("unknown", 64'(want.unk), 64'(i_out_user[3]));
            compare_field("last_of_run", 64'(want.last), 64'(i_out_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_items.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_item();
            if (i_in_valid && i_in_ready) predict_byte(i_in_byte, i_in_start, i_in_end);
        end
        o_pending    <= expected_items.size();
        o_mismatches <= fail_count;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the remote id bitmap frame parser: a few
// hand-made frames for the header and end cases, then random frames with
// chained bitmaps, random field content and assorted lengths and buffer
// ends, mixed with broken headers and stray bytes, under random stalls save for one stretch without them.
// ----------------------------------------------------------------------------
module tb;
    import ridbfp_pkg::*;

    logic         clk     = 1'b0;
    logic         rst_n   = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [7:0]   s_data  = '0;
    logic [0:0]   s_user  = '0;
    logic         s_last  = 1'b0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [103:0] m_data;
    logic [3:0]   m_user;
    logic         m_last;

    int           mismatches;
    int           pending;
    bit           stall_on = 1'b1;
    logic [7:0]   frame_bytes [$];
    int           random_bytes = 0;

    always #4 clk = ~clk;

    remote_id_bitmap_frame_parser u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    frame_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_byte    (s_data),
        .i_in_start   (s_user[0]),
        .i_in_end     (s_last),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_out_user   (m_user),
        .i_out_last   (m_last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        m_ready <= !stall_on || ($urandom_range(99) >= 34);
    end

    task automatic send_item(input logic [7:0] d, input bit st, input bit fin);
        while (stall_on && $urandom_range(99) < 34) begin
            @(negedge clk);
            s_valid <= 1'b0;
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_data  <= d;
        s_user  <= st;
        s_last  <= fin;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    task automatic send_frame_bytes(input bit with_start, input int end_at);
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_item(frame_bytes[i], with_start && i == 0, i == end_at);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_random_frame();
        logic [7:0] bm [3];
        logic [7:0] b;
        int         nb;
        int         nfb;
        int         content;
        int         len;
        int         r;
        int         end_at;
        bm[0] = '0;
        bm[1] = '0;
        bm[2] = '0;
        r  = $urandom_range(99);
        nb = (r < 70) ? $urandom_range(1, 3) :
             (r < 92) ? $urandom_range(4, MAX_BITMAP_BYTES) :
                        $urandom_range(MAX_BITMAP_BYTES + 1, MAX_BITMAP_BYTES + 2);
        frame_bytes.delete();
        frame_bytes.push_back(MAGIC_BYTE);
        b = 8'($urandom);
        frame_bytes.push_back(b);
        frame_bytes.push_back(8'd0);
        for (int i = 0; i < nb; i++) begin
            case ($urandom_range(2))
                0:       b = 8'($urandom);
                1:       b = 8'($urandom & $urandom);
                default: b = 8'($urandom & $urandom & $urandom);
            endcase
            if (i < nb - 1) b[0] = 1'b1;
            else if (nb < MAX_BITMAP_BYTES) b[0] = 1'b0;
            if (i < 3) bm[i] = b;
            frame_bytes.push_back(b);
        end
        nfb = 0;
        for (int n = 1; n <= FIELD_COUNT; n++) begin
            if (bm[(n - 1) / 7][7 - (n - 1) % 7]) nfb += int'(f_field_len(5'(n)));
        end
        for (int j = 0; j < nfb; j++) begin
            b = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
            frame_bytes.push_back(b);
        end
        content = nb + nfb;
        r = $urandom_range(99);
        if (r < 60) len = content;
        else if (r < 75) len = content + $urandom_range(20);
        else if (r < 90) len = $urandom_range(content);
        else len = $urandom_range(255);
        if (len > 255) len = 255;
        frame_bytes[2] = 8'(len);
        r = $urandom_range(99);
        if (r < 60) begin
            end_at = frame_bytes.size() - 1;
        end else if (r < 75) begin
            end_at = $urandom_range(frame_bytes.size() - 1);
            while (frame_bytes.size() > end_at + 1) void'(frame_bytes.pop_back());
        end else if (r < 88) begin
            end_at = -1;
        end else begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom);
                frame_bytes.push_back(b);
            end
            end_at = frame_bytes.size() - 1;
        end
        random_bytes += frame_bytes.size();
        send_frame_bytes(1'b1, end_at);
    endtask

    task automatic send_broken_header();
        logic [7:0] b;
        int         n;
        int         end_at;
        n = $urandom_range(1, 3);
        frame_bytes.delete();
        for (int i = 0; i < n; i++) begin
            b = (i == 0 && $urandom_range(1)) ? MAGIC_BYTE : 8'($urandom);
            frame_bytes.push_back(b);
        end
        end_at = $urandom_range(1) ? $urandom_range(n - 1) : -1;
        while (end_at >= 0 && frame_bytes.size() > end_at + 1) void'(frame_bytes.pop_back());
        random_bytes += frame_bytes.size();
        send_frame_bytes(1'b1, end_at);
    endtask

    // stray bytes with no frame start
    task automatic send_noise();
        logic [7:0] b;
        int         n;
        n = $urandom_range(1, 4);
        frame_bytes.delete();
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
        end
        send_frame_bytes(1'b0, $urandom_range(1) ? $urandom_range(n - 1) : -1);
    endtask

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int frames;
        int kind;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // bad magic
        frame_bytes = '{8'h00};
        send_frame_bytes(1'b1, -1);
        // buffer ends on the magic byte
        frame_bytes = '{8'hFF};
        send_frame_bytes(1'b1, 0);
        // buffer ends on the version byte
        frame_bytes = '{8'hFF, 8'h00};
        send_frame_bytes(1'b1, 1);
        // buffer ends on the length byte
        frame_bytes = '{8'hFF, 8'h7F, 8'h80};
        send_frame_bytes(1'b1, 2);
        // byte with no frame open
        frame_bytes = '{8'h55};
        send_frame_bytes(1'b0, -1);
        // restart mid header, then one short field and a byte after the end
        frame_bytes = '{8'hFF, 8'h01};
        send_frame_bytes(1'b1, -1);
        frame_bytes = '{8'hFF, 8'h01, 8'h02, 8'h20, 8'hAB, 8'h77};
        send_frame_bytes(1'b1, 5);
        // field runs past the length
        frame_bytes = '{8'hFF, 8'h00, 8'h01, 8'h20};
        send_frame_bytes(1'b1, -1);
        // buffer ends inside a field
        frame_bytes = '{8'hFF, 8'hFF, 8'h03, 8'h02, 8'h34};
        send_frame_bytes(1'b1, 4);
        wait_drained();

        frames = 0;
        while (random_bytes < 750) begin
            stall_on = !(random_bytes >= 250 && random_bytes < 450);
            kind = $urandom_range(99);
            if (kind < 78) send_random_frame();
            else if (kind < 90) send_broken_header();
            else send_noise();
            frames++;
            if (frames % 12 == 0) wait_drained();
        end
        stall_on = 1'b1;

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
